FILE: design/sssc_pkg.sv
// Shared types, constants and helpers for the shelf / saturator / shelf chain.
// Holds the tanh table builder, rounding and saturation helpers and FSM codes.
// No dependencies.
package sssc_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int SIG_FRAC     = SAMPLE_BITS - 1;
  localparam int STATE_BITS   = 40;
  localparam int COEF_BITS    = 20;
  localparam int COEF_FRAC    = 18;
  localparam int GAIN_FRAC    = 16;
  localparam int BIAS_FRAC    = 18;
  localparam int MIX_FRAC     = 16;
  localparam int INTERP_BITS  = 16;
  localparam int TANH_ENTRIES = 256;
  localparam int TANH_LOG     = $clog2(TANH_ENTRIES);
  localparam int TANH_FRAC    = 30;
  localparam int EXP_FRAC     = 31;
  localparam int TANH_SH      = SIG_FRAC + 2;
  localparam int CHANNELS_DEF = 2;
  localparam int WET_ONE      = 65536;

  localparam int ACC_W   = 64;
  localparam int MCAND_W = 42;
  localparam int MPLR_W  = 21;
  localparam int CNT_W   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  localparam logic [CFG_IDX_W-1:0] REG_PRE_FWD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_FB     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POST_FWD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST_FB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TREBLE_FWD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TREBLE_FB  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WET        = 3'd7;

  typedef struct packed {
    logic signed [MCAND_W-1:0] mcand;
    logic signed [MPLR_W-1:0]  mplr;
    logic [CNT_W-1:0]          nbits;
    logic                      accum;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BQ0, ST_BQ1, ST_BQ2, ST_BQ3, ST_BQ4, ST_GAIN,
    ST_TLOOK, ST_TRD0, ST_TRD1, ST_TMUL, ST_MIX, ST_FIN
  } state_t;

  typedef logic [TANH_ENTRIES:0][TANH_FRAC:0] tanh_table_t;

  // exp(-8/N) Taylor step in Q31
  localparam logic [63:0] TANH_STEP =
      ((64'd8 << EXP_FRAC) + 64'(TANH_ENTRIES / 2)) / 64'(TANH_ENTRIES);

  // restoring unsigned division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4k/N) in Q1.30, from exp(-8/N) by Taylor series and repeated products
  function automatic tanh_table_t build_tanh();
    logic [63:0] one;
    logic [63:0] step;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    tanh_table_t tab;
    one  = 64'd1 << EXP_FRAC;
    step = TANH_STEP;
    term = one;
    r    = one;
    e    = one;
    for (int n = 1; n <= 14; n++) begin
      term = udiv64((term * step + (one >> 1)) >> EXP_FRAC, 64'(n));
      if ((n & 1) == 1) r = r - term;
      else r = r + term;
    end
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      num    = (one - e) << TANH_FRAC;
      den    = one + e;
      tab[k] = (TANH_FRAC+1)'(udiv64(num + (den >> 1), den));
      e      = (e * r + (one >> 1)) >> EXP_FRAC;
    end
    return tab;
  endfunction

  localparam tanh_table_t TANH_TABLE = build_tanh();

  // floor((v + half lsb) / 2^n)
  function automatic logic signed [ACC_W-1:0] rnd_asr(input logic signed [ACC_W-1:0] v,
                                                      input int n);
    logic signed [ACC_W-1:0] half;
    half = 64'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[STATE_BITS-1:0];
    else if (v < lo) return lo[STATE_BITS-1:0];
    else return v[STATE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    else if (v < lo) return lo[SAMPLE_BITS-1:0];
    else return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

FILE: design/sssc_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
// Uses sssc_pkg for the command and status types.
module sssc_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  sssc_pkg::mac_cmd_t                     cmd,
  output sssc_pkg::mac_stat_t                    stat,
  output logic signed [sssc_pkg::ACC_W-1:0]      acc
);

  logic signed [sssc_pkg::ACC_W-1:0]  mc;
  logic [sssc_pkg::MPLR_W-1:0]        mr;
  logic [sssc_pkg::CNT_W-1:0]         cnt;
  logic [sssc_pkg::CNT_W-1:0]         nb;
  logic                               busy;
  logic                               done;
  logic                               last;
  logic signed [sssc_pkg::ACC_W-1:0]  addend;

  assign last = (cnt == nb - sssc_pkg::CNT_W'(1));

  // top multiplier bit carries negative weight
  always_comb begin
    if (!mr[0]) addend = '0;
    else if (last) addend = -mc;
    else addend = mc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= sssc_pkg::ACC_W'(cmd.mcand);
      mr  <= cmd.mplr;
      cnt <= '0;
      nb  <= cmd.nbits;
      if (!cmd.accum) acc <= '0;
    end else if (busy) begin
      acc <= acc + addend;
      mc  <= mc <<< 1;
      mr  <= mr >> 1;
      cnt <= cnt + sssc_pkg::CNT_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: design/sssc_state.sv
// Per-channel biquad state store with registered read and per-entry valid bits.
// Uses sssc_pkg for the state word width.
module sssc_state #(
  parameter int DEPTH = sssc_pkg::CHANNELS_DEF * 6
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [$clog2(DEPTH)-1:0]                  rd_addr,
  output logic signed [sssc_pkg::STATE_BITS-1:0]    rd_data,
  input  logic                                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]                  wr_addr,
  input  logic signed [sssc_pkg::STATE_BITS-1:0]    wr_data
);

  logic signed [sssc_pkg::STATE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                       valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

FILE: design/shelf_saturate_shelf_chain.sv
// Stereo low shelf, biased tanh saturator, de-emphasis shelf and high shelf,
// blended with the dry sample. All products run on one bit-serial MAC, one
// multiplier bit per cycle: fifteen 20-bit coefficient products, the gain
// product, two tanh lookups with a 17-bit interpolation product each and the
// 18-bit wet blend. A bypassed item goes straight to the output register.
// The next item is accepted while a finished result waits at the output.
// Depends on sssc_pkg, sssc_mac and sssc_state.
module shelf_saturate_shelf_chain #(
  parameter int CHANNELS = sssc_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sssc_pkg::SAMPLE_BITS-1:0]     s_tdata,   // [23:0] in_sample
  input  logic [0:0]                           s_tuser,   // [0] channel
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sssc_pkg::SAMPLE_BITS-1:0]     m_tdata,   // [23:0] out_sample
  output logic [0:0]                           m_tuser,   // [0] out_channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sssc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sssc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = CHANNELS * 6;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = sssc_pkg::TANH_FRAC + 1;
  localparam int RW    = sssc_pkg::SIG_FRAC + 2;

  sssc_pkg::state_t state, state_next;

  logic [59:0] pre_fwd, post_fwd, treble_fwd;
  logic [39:0] pre_fb, post_fb, treble_fb, shaper;
  logic [16:0] wet_reg;

  logic                                       issued;
  logic [1:0]                                 stage;
  logic                                       ch;
  logic signed [sssc_pkg::SAMPLE_BITS-1:0]    x;
  logic signed [sssc_pkg::STATE_BITS-1:0]     cur;
  logic signed [sssc_pkg::STATE_BITS-1:0]     y;
  logic signed [sssc_pkg::ACC_W-1:0]          targ;
  logic                                       tneg;
  logic                                       tpass;
  logic [sssc_pkg::TANH_LOG:0]                taddr;
  logic [sssc_pkg::INTERP_BITS-1:0]           fr;
  logic [TW-1:0]                              t0, t1;
  logic signed [RW-1:0]                       tha;
  logic signed [sssc_pkg::SAMPLE_BITS-1:0]    res;
  logic                                       ovalid;
  logic [sssc_pkg::SAMPLE_BITS-1:0]           osample;
  logic                                       och;

  logic                                       mac_start;
  sssc_pkg::mac_cmd_t                         mac_cmd;
  sssc_pkg::mac_stat_t                        mac_stat;
  logic signed [sssc_pkg::ACC_W-1:0]          acc;

  logic [AW-1:0]                              rd_addr, wr_addr;
  logic                                       wr_en;
  logic signed [sssc_pkg::STATE_BITS-1:0]     s_rd, wr_data;

  logic [16:0]                                wet_eff;
  logic                                       bypass;
  logic                                       accept;
  logic                                       op_done;
  logic [59:0]                                fwd_sel;
  logic [39:0]                                fb_sel;
  logic signed [sssc_pkg::ACC_W-1:0]          bias;
  logic signed [sssc_pkg::ACC_W-1:0]          acc_coef;
  logic signed [sssc_pkg::STATE_BITS-1:0]     y_calc;
  logic signed [sssc_pkg::MCAND_W-1:0]        neg_y;
  logic signed [sssc_pkg::ACC_W-1:0]          mag, pos, idx;
  logic                                       in_table;
  logic signed [sssc_pkg::ACC_W-1:0]          t_int, t_sc;
  logic signed [RW-1:0]                       tres;
  logic signed [sssc_pkg::ACC_W-1:0]          mix_o;
  logic                                       out_load;

  sssc_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .cmd   (mac_cmd),
    .stat  (mac_stat),
    .acc   (acc)
  );

  sssc_state #(.DEPTH(DEPTH)) u_state (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (s_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_fwd    <= 60'd262144;
      pre_fb     <= '0;
      post_fwd   <= 60'd262144;
      post_fb    <= '0;
      treble_fwd <= 60'd262144;
      treble_fb  <= '0;
      shaper     <= 40'd65536;
      wet_reg    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sssc_pkg::REG_PRE_FWD:    pre_fwd    <= cfg_data;
        sssc_pkg::REG_PRE_FB:     pre_fb     <= cfg_data[39:0];
        sssc_pkg::REG_POST_FWD:   post_fwd   <= cfg_data;
        sssc_pkg::REG_POST_FB:    post_fb    <= cfg_data[39:0];
        sssc_pkg::REG_TREBLE_FWD: treble_fwd <= cfg_data;
        sssc_pkg::REG_TREBLE_FB:  treble_fb  <= cfg_data[39:0];
        sssc_pkg::REG_SHAPER:     shaper     <= cfg_data[39:0];
        sssc_pkg::REG_WET:        wet_reg    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign wet_eff = (wet_reg > 17'(sssc_pkg::WET_ONE)) ? 17'(sssc_pkg::WET_ONE) : wet_reg;
  assign bypass  = (wet_eff == '0) || (int'(s_tuser[0]) >= CHANNELS);
  assign s_tready = (state == sssc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op_done  = issued && mac_stat.done;

  always_comb begin
    unique case (stage)
      2'd0: begin
        fwd_sel = pre_fwd;
        fb_sel  = pre_fb;
      end
      2'd1: begin
        fwd_sel = post_fwd;
        fb_sel  = post_fb;
      end
      default: begin
        fwd_sel = treble_fwd;
        fb_sel  = treble_fb;
      end
    endcase
  end

  // datapath arithmetic
  assign bias     = sssc_pkg::ACC_W'($signed(shaper[39:20]))
                    <<< (sssc_pkg::SIG_FRAC - sssc_pkg::BIAS_FRAC);
  assign acc_coef = sssc_pkg::rnd_asr(acc, sssc_pkg::COEF_FRAC);
  assign y_calc   = sssc_pkg::sat_state(acc_coef + sssc_pkg::ACC_W'(s_rd));
  assign neg_y    = -sssc_pkg::MCAND_W'(y);

  assign mag      = targ[sssc_pkg::ACC_W-1] ? -targ : targ;
  assign pos      = mag <<< sssc_pkg::TANH_LOG;
  assign idx      = pos >>> sssc_pkg::TANH_SH;
  assign in_table = (idx < sssc_pkg::ACC_W'(sssc_pkg::TANH_ENTRIES));

  assign t_int = sssc_pkg::ACC_W'($signed({1'b0, t0}))
                 + sssc_pkg::rnd_asr(acc, sssc_pkg::INTERP_BITS);
  assign t_sc  = sssc_pkg::rnd_asr(t_int, sssc_pkg::TANH_FRAC - sssc_pkg::SIG_FRAC);
  assign tres  = tneg ? -t_sc[RW-1:0] : t_sc[RW-1:0];

  assign mix_o = sssc_pkg::ACC_W'(x) + sssc_pkg::rnd_asr(acc, sssc_pkg::MIX_FRAC);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sssc_pkg::ST_IDLE:  if (accept) state_next = bypass ? sssc_pkg::ST_FIN : sssc_pkg::ST_BQ0;
      sssc_pkg::ST_BQ0:   if (op_done) state_next = sssc_pkg::ST_BQ1;
      sssc_pkg::ST_BQ1:   if (op_done) state_next = sssc_pkg::ST_BQ2;
      sssc_pkg::ST_BQ2:   if (op_done) state_next = sssc_pkg::ST_BQ3;
      sssc_pkg::ST_BQ3:   if (op_done) state_next = sssc_pkg::ST_BQ4;
      sssc_pkg::ST_BQ4: begin
        if (op_done) begin
          unique case (stage)
            2'd0:    state_next = sssc_pkg::ST_GAIN;
            2'd1:    state_next = sssc_pkg::ST_BQ0;
            default: state_next = sssc_pkg::ST_MIX;
          endcase
        end
      end
      sssc_pkg::ST_GAIN:  if (op_done) state_next = sssc_pkg::ST_TLOOK;
      sssc_pkg::ST_TLOOK: state_next = sssc_pkg::ST_TRD0;
      sssc_pkg::ST_TRD0:  state_next = sssc_pkg::ST_TRD1;
      sssc_pkg::ST_TRD1:  state_next = sssc_pkg::ST_TMUL;
      sssc_pkg::ST_TMUL:  if (op_done) state_next = tpass ? sssc_pkg::ST_BQ0 : sssc_pkg::ST_TLOOK;
      sssc_pkg::ST_MIX:   if (op_done) state_next = sssc_pkg::ST_FIN;
      sssc_pkg::ST_FIN:   if (!ovalid || m_tready) state_next = sssc_pkg::ST_IDLE;
      default:            state_next = sssc_pkg::ST_IDLE;
    endcase
  end

  // outputs: MAC commands and state store access
  always_comb begin
    mac_cmd.mcand = sssc_pkg::MCAND_W'(cur);
    mac_cmd.mplr  = sssc_pkg::MPLR_W'($signed(fwd_sel[19:0]));
    mac_cmd.nbits = sssc_pkg::CNT_W'(sssc_pkg::COEF_BITS);
    mac_cmd.accum = 1'b0;
    mac_start     = 1'b0;
    wr_en         = 1'b0;
    wr_data       = y_calc;
    unique case (state)
      sssc_pkg::ST_BQ0: mac_start = !issued;
      sssc_pkg::ST_BQ1: begin
        mac_start    = !issued;
        mac_cmd.mplr = sssc_pkg::MPLR_W'($signed(fwd_sel[39:20]));
      end
      sssc_pkg::ST_BQ2: begin
        mac_start     = !issued;
        mac_cmd.mcand = neg_y;
        mac_cmd.mplr  = sssc_pkg::MPLR_W'($signed(fb_sel[19:0]));
        mac_cmd.accum = 1'b1;
        wr_en         = op_done;
      end
      sssc_pkg::ST_BQ3: begin
        mac_start    = !issued;
        mac_cmd.mplr = sssc_pkg::MPLR_W'($signed(fwd_sel[59:40]));
      end
      sssc_pkg::ST_BQ4: begin
        mac_start     = !issued;
        mac_cmd.mcand = neg_y;
        mac_cmd.mplr  = sssc_pkg::MPLR_W'($signed(fb_sel[39:20]));
        mac_cmd.accum = 1'b1;
        wr_en         = op_done;
        wr_data       = sssc_pkg::sat_state(acc_coef);
      end
      sssc_pkg::ST_GAIN: begin
        mac_start     = !issued;
        mac_cmd.mcand = sssc_pkg::MCAND_W'(y);
        mac_cmd.mplr  = $signed({1'b0, shaper[19:0]});
        mac_cmd.nbits = sssc_pkg::CNT_W'(sssc_pkg::MPLR_W);
      end
      sssc_pkg::ST_TMUL: begin
        mac_start     = !issued;
        mac_cmd.mcand = sssc_pkg::MCAND_W'($signed({1'b0, t1}) - $signed({1'b0, t0}));
        mac_cmd.mplr  = sssc_pkg::MPLR_W'($signed({1'b0, fr}));
        mac_cmd.nbits = sssc_pkg::CNT_W'(sssc_pkg::INTERP_BITS + 1);
      end
      sssc_pkg::ST_MIX: begin
        mac_start     = !issued;
        mac_cmd.mcand = sssc_pkg::MCAND_W'(y) - sssc_pkg::MCAND_W'(x);
        mac_cmd.mplr  = sssc_pkg::MPLR_W'($signed({1'b0, wet_eff}));
        mac_cmd.nbits = sssc_pkg::CNT_W'(18);
      end
      default: ;
    endcase
  end

  // s0 is read for the b0 product; s1 for the s0 update, then both are rewritten
  assign rd_addr = AW'(int'(ch) * 6 + int'(stage) * 2 + ((state == sssc_pkg::ST_BQ0) ? 0 : 1));
  assign wr_addr = AW'(int'(ch) * 6 + int'(stage) * 2 + ((state == sssc_pkg::ST_BQ2) ? 0 : 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sssc_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mac_start) issued <= 1'b1;
      else if (op_done) issued <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sssc_pkg::ST_IDLE: begin
        if (accept) begin
          ch    <= s_tuser[0];
          x     <= $signed(s_tdata);
          res   <= $signed(s_tdata);
          cur   <= sssc_pkg::STATE_BITS'($signed(s_tdata));
          stage <= 2'd0;
        end
      end
      sssc_pkg::ST_BQ0: if (op_done) y <= y_calc;
      sssc_pkg::ST_BQ4: begin
        if (op_done && stage == 2'd1) begin
          cur   <= y;
          stage <= 2'd2;
        end
      end
      sssc_pkg::ST_GAIN: begin
        if (op_done) begin
          targ  <= sssc_pkg::rnd_asr(acc, sssc_pkg::GAIN_FRAC) + bias;
          tpass <= 1'b0;
        end
      end
      sssc_pkg::ST_TLOOK: begin
        tneg  <= targ[sssc_pkg::ACC_W-1];
        taddr <= in_table ? idx[sssc_pkg::TANH_LOG:0]
                          : (sssc_pkg::TANH_LOG+1)'(sssc_pkg::TANH_ENTRIES);
        fr    <= pos[sssc_pkg::TANH_SH-1 -: sssc_pkg::INTERP_BITS];
      end
      sssc_pkg::ST_TRD0: begin
        t0 <= sssc_pkg::TANH_TABLE[taddr];
        // saturated lookups reuse the last point, so the slope is zero
        if (taddr != (sssc_pkg::TANH_LOG+1)'(sssc_pkg::TANH_ENTRIES))
          taddr <= taddr + (sssc_pkg::TANH_LOG+1)'(1);
      end
      sssc_pkg::ST_TRD1: t1 <= sssc_pkg::TANH_TABLE[taddr];
      sssc_pkg::ST_TMUL: begin
        if (op_done) begin
          if (!tpass) begin
            tha   <= tres;
            targ  <= bias;
            tpass <= 1'b1;
          end else begin
            cur   <= sssc_pkg::STATE_BITS'(tha) - sssc_pkg::STATE_BITS'(tres);
            stage <= 2'd1;
          end
        end
      end
      sssc_pkg::ST_MIX: if (op_done) res <= sssc_pkg::sat_sample(mix_o);
      default: ;
    endcase
  end

  // output register
  assign out_load = (state == sssc_pkg::ST_FIN) && (!ovalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      osample <= res;
      och     <= ch;
    end
  end

  assign m_tvalid   = ovalid;
  assign m_tdata    = osample;
  assign m_tuser[0] = och;

endmodule

FILE: sim/shelf_chain_checker.sv
// Checker for shelf_saturate_shelf_chain: watches the config, input and output
// channels, predicts each output item from a model of its own and compares.
// Depends on sssc_pkg.
`timescale 1ns / 1ps
module shelf_chain_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [sssc_pkg::SAMPLE_BITS-1:0]  s_tdata,
  input  logic [0:0]                        s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [sssc_pkg::SAMPLE_BITS-1:0]  m_tdata,
  input  logic [0:0]                        m_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [sssc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sssc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending
);

  typedef struct {
    logic       chan;
    logic [23:0] sample;
  } audio_item_t;

  localparam int NCH = sssc_pkg::CHANNELS_DEF;
  localparam int NTAB = sssc_pkg::TANH_ENTRIES;

  logic [59:0] coef_regs [8];
  longint      shelf_mem [NCH*6];
  longint      tanh_pts [NTAB+1];
  audio_item_t sample_queue [$];

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n-1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits-1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint sx20(logic [59:0] v, int lsb);
    logic signed [19:0] c;
    c = v[lsb +: 20];
    return longint'(c);
  endfunction

  // transposed direct form II, state words at base, base+1
  function automatic longint run_shelf(longint x_in, logic [59:0] fw, logic [59:0] fb,
                                       int base);
    longint x, y, s0, s1;
    x  = clamp(x_in, 40);
    y  = clamp(round_shift(sx20(fw, 0) * x, 18) + shelf_mem[base], 40);
    s0 = clamp(round_shift(sx20(fw, 20) * x - sx20(fb, 0) * y, 18) + shelf_mem[base+1],
               40);
    s1 = clamp(round_shift(sx20(fw, 40) * x - sx20(fb, 20) * y, 18), 40);
    shelf_mem[base]   = s0;
    shelf_mem[base+1] = s1;
    return y;
  endfunction

  function automatic longint tanh_lookup(longint a);
    longint mag, pos, idx, fr, t;
    mag = a < 0 ? -a : a;
    pos = mag * NTAB;
    idx = pos >>> 25;
    if (idx >= NTAB) t = tanh_pts[NTAB];
    else begin
      fr = (pos & ((longint'(1) <<< 25) - 1)) >>> 9;
      t  = tanh_pts[idx] + round_shift((tanh_pts[idx+1] - tanh_pts[idx]) * fr, 16);
    end
    t = round_shift(t, 7);
    return a < 0 ? -t : t;
  endfunction

  function automatic logic [23:0] predict_sample(logic chan, logic [23:0] din);
    longint x, wet, p, drv, bias, y, h, o;
    int b;
    x   = longint'($signed(din));
    wet = coef_regs[7] > 65536 ? 65536 : longint'(coef_regs[7]);
    if (wet == 0 || chan >= NCH) return din;
    b    = chan * 6;
    p    = run_shelf(x, coef_regs[0], coef_regs[1], b);
    drv  = round_shift(p * longint'(coef_regs[6][19:0]), 16);
    bias = sx20(coef_regs[6], 20) * 32;
    y    = tanh_lookup(drv + bias) - tanh_lookup(bias);
    h    = run_shelf(y, coef_regs[2], coef_regs[3], b + 2);
    h    = run_shelf(h, coef_regs[4], coef_regs[5], b + 4);
    o    = x + round_shift(wet * (h - x), 16);
    return 24'(clamp(o, 24));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    longint one, step, term, r, e, num, den;
    one  = longint'(1) <<< 31;
    step = ((longint'(8) <<< 31) + NTAB / 2) / NTAB;
    term = one; r = one; e = one;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * step + (one >>> 1)) >>> 31) / n;
      if (n % 2) r -= term; else r += term;
    end
    for (int k = 0; k <= NTAB; k++) begin
      num = (one - e) <<< 30;
      den = one + e;
      tanh_pts[k] = (num + den / 2) / den;
      e = (e * r + (one >>> 1)) >>> 31;
    end
  end

  always @(posedge clk) begin
    audio_item_t exp_item;
    if (rst) begin
      fail_count = 0;
      sample_queue.delete();
      coef_regs = '{60'd262144, 60'd0, 60'd262144, 60'd0, 60'd262144, 60'd0, 60'd65536,
                    60'd0};
      for (int i = 0; i < NCH*6; i++) shelf_mem[i] = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sssc_pkg::REG_PRE_FB, sssc_pkg::REG_POST_FB, sssc_pkg::REG_TREBLE_FB,
          sssc_pkg::REG_SHAPER:
            coef_regs[cfg_index] = {20'd0, cfg_data[39:0]};
          sssc_pkg::REG_WET: coef_regs[cfg_index] = {43'd0, cfg_data[16:0]};
          default: coef_regs[cfg_index] = cfg_data;
        endcase
      end
      if (s_tvalid && s_tready) begin
        exp_item.chan   = s_tuser[0];
        exp_item.sample = predict_sample(s_tuser[0], s_tdata);
        sample_queue.push_back(exp_item);
      end
      if (m_tvalid && m_tready) begin
        if (sample_queue.size() == 0) report_mismatch("unexpected item", m_tdata, 0);
        else begin
          exp_item = sample_queue.pop_front();
          if (m_tuser[0] !== exp_item.chan)
            report_mismatch("out_channel", m_tuser[0], exp_item.chan);
          if (m_tdata !== exp_item.sample)
            report_mismatch("out_sample", $signed(m_tdata), $signed(exp_item.sample));
        end
      end
    end
    pending = sample_queue.size();
  end
endmodule

FILE: sim/shelf_saturate_shelf_chain_tb.sv
// Top of the testbench for shelf_saturate_shelf_chain: clock, reset, config
// writes and sample stimulus with random idling; verdict from the checker.
// Depends on sssc_pkg, the block and shelf_chain_checker.
`timescale 1ns / 1ps
module shelf_saturate_shelf_chain_tb;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0, s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid, m_tready = 0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [59:0] cfg_data = '0;
  int          fail_count, pending;
  int          send_idle_pct = 33, recv_idle_pct = 61;
  int          hold_recv = 0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  shelf_saturate_shelf_chain dut (.*);

  shelf_chain_checker chk (.*);

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_recv > 0) begin
      m_tready <= 0;
      hold_recv <= hold_recv - 1;
    end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
        || rst || hold_recv > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [59:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // returns at the falling edge after the accept, still offering; the next
  // call drops valid or offers its own sample, and drain_results drops valid
  task automatic send_sample(logic chan, logic [23:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1; s_tuser <= chan; s_tdata <= val;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  function automatic logic [19:0] rand_coef();
    case ($urandom_range(5))
      0: return 20'h7ffff;
      1: return 20'h80000;
      2: return 20'(($urandom_range(1) ? 1 : -1) * $urandom_range(131072));
      default: return 20'($urandom);
    endcase
  endfunction

  // stable-ish shelves mostly, extremes sometimes
  task automatic load_settings(int mode);
    logic [59:0] fw;
    logic [39:0] fb;
    for (int k = 0; k < 3; k++) begin
      if (mode == 0) begin
        fw = {rand_coef(), rand_coef(), rand_coef()};
        fb = {rand_coef(), rand_coef()};
      end else begin
        fw = {20'($urandom_range(60000)), 20'(-$urandom_range(60000)),
              20'(200000 + $urandom_range(60000))};
        fb = {20'($urandom_range(60000)), 20'(-$urandom_range(100000))};
      end
      write_reg(3'(sssc_pkg::REG_PRE_FWD + 2*k), fw);
      write_reg(3'(sssc_pkg::REG_PRE_FB + 2*k), 60'({$urandom, $urandom}));
      write_reg(3'(sssc_pkg::REG_PRE_FB + 2*k), {20'd0, fb});
    end
    write_reg(sssc_pkg::REG_SHAPER,
              mode == 0 ? 60'({$urandom, $urandom})
                        : {20'd0, 20'($urandom), 20'($urandom_range(400000))});
    write_reg(sssc_pkg::REG_WET,
              mode == 0 ? 60'({$urandom, $urandom}) : 60'($urandom_range(131071)));
  endtask

  logic [23:0] edge_vals [6] = '{24'h7fffff, 24'h800000, 24'h000000, 24'h000001,
                                 24'hffffff, 24'h400000};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: reset settings with bypass, then full wet, extremes of fields
    foreach (edge_vals[i]) send_sample(i[0], edge_vals[i]);
    drain_results();
    write_reg(sssc_pkg::REG_WET, 60'd65536);
    write_reg(sssc_pkg::REG_SHAPER, {20'd0, 20'h7ffff, 20'hfffff});
    foreach (edge_vals[i]) send_sample(i[0], edge_vals[i]);
    drain_results();
    write_reg(sssc_pkg::REG_SHAPER, {20'd0, 20'h80000, 20'h10000});
    write_reg(sssc_pkg::REG_WET, 60'h1ffff);
    foreach (edge_vals[i]) send_sample(~i[0], edge_vals[i]);
    drain_results();
    write_reg(sssc_pkg::REG_WET, 60'd1);
    for (int i = 0; i < 4; i++) send_sample(i[0], edge_vals[i]);
    drain_results();
    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 61; recv_idle_pct = 33; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      for (int blk = 0; blk < 5; blk++) begin
        load_settings(blk == 0 ? 0 : 1);
        if (blk == 2) hold_recv = 4000;
        for (int n = 0; n < 100; n++)
          send_sample(1'($urandom_range(1)),
                      ($urandom_range(9) == 0) ? edge_vals[$urandom_range(5)] : 24'($urandom));
        drain_results();
      end
    end
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: sim.f
design/sssc_pkg.sv
design/sssc_mac.sv
design/sssc_state.sv
design/shelf_saturate_shelf_chain.sv
sim/shelf_chain_checker.sv
sim/shelf_saturate_shelf_chain_tb.sv
